// ===== rtl/tss_pkg.sv =====
// Shared types, constants and fixed-point helpers of the tridiagonal sweep solver.
// No dependencies; the solver and the divider import this package.
package tss_pkg;

  localparam int DATA_W = 32;   // Q16.16 word
  localparam int NODE_W = 6;    // node_index port width
  localparam int PROD_W = 48;   // rounded Q16.16 product, signed
  localparam int DIV_W  = 49;   // divider operand, signed
  localparam int MAG_W  = 48;   // divider operand magnitude
  localparam int CFG_W  = 2;    // configuration index width

  localparam logic [CFG_W-1:0] CFG_LEFT_KAPPA  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_RIGHT_KAPPA = 2'd1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic signed [DIV_W-1:0] ONE_Q16 = 49'sd65536;
  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_MA, ST_ROW_MB, ST_ROW_DA, ST_ROW_WA, ST_ROW_WB,
    ST_CL_MB, ST_CL_MA, ST_CL_DV, ST_CL_WY,
    ST_BK_RD, ST_BK_MUL, ST_BK_ADD,
    ST_EM_RD, ST_EM_OUT
  } tss_state_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_FIN
  } tss_div_state_t;

  // divider result as seen by the controller
  typedef struct packed {
    logic              done;
    logic              zero;
    logic [DATA_W-1:0] quot;
  } tss_div_res_t;

  // exact product rounded to Q16.16, ties away from zero
  function automatic logic signed [PROD_W-1:0] qround(input logic signed [63:0] p);
    logic [63:0]       m;
    logic [PROD_W-1:0] r;
    m = p[63] ? 64'(-p) : 64'(p);
    r = PROD_W'((m + 64'h8000) >> 16);
    return p[63] ? PROD_W'(-r) : r;
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [DIV_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > 49'sh0_7FFF_FFFF) r = POS_MAX;
    else if (v < -49'sh0_8000_0000) r = NEG_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/tridiagonal_sweep_solver.sv =====
// Tridiagonal sweep solver: forward coefficients in alpha/beta RAMs, backward
// sweep into a solution RAM, then a readout in node order.
// A row runs two divisions, one after the other, on the single shared divider; close runs one
// division, the backward sweep and the readout; results come one item at a time.
// Reset (rst, synchronous) clears control, row count, error flag and both kappas;
// RAM contents stay undefined. Results cannot be stalled by the receiver.
module tridiagonal_sweep_solver import tss_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [DATA_W-1:0] sub_coef,
  input  logic [DATA_W-1:0] super_coef,
  input  logic [DATA_W-1:0] diag_coef,
  input  logic [DATA_W-1:0] rhs_value,
  input  logic [DATA_W-1:0] boundary_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output logic              result_valid,
  output logic [DATA_W-1:0] solution,
  output logic [NODE_W-1:0] node_index,
  output logic              last,
  output logic              div_error
);

  localparam int AW = $clog2(MAX_NODES);

  tss_state_t state, state_next;

  logic [DATA_W-1:0] left_kappa, right_kappa;
  logic [AW-1:0]     row_count;
  logic              error_seen;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     n_r;
  logic signed [DATA_W-1:0] a_r, b_r, c_r, f_r, bv_r;
  logic signed [63:0]       prod;
  logic signed [DIV_W-1:0]  den_r, num_r;
  logic [DATA_W-1:0]        y_r;

  logic [DATA_W-1:0] alpha_q, beta_q, sol_q;
  logic              alpha_we, beta_we, sol_we;
  logic [AW-1:0]     alpha_wa, beta_wa, sol_wa, ab_ra;
  logic [DATA_W-1:0] alpha_wd, beta_wd, sol_wd;

  logic signed [DATA_W-1:0] mul_x, mul_y;
  logic                     dv_start;
  logic signed [DIV_W-1:0]  dv_num, dv_den;
  tss_div_res_t             dv;
  logic                     accept;
  logic [DATA_W-1:0]        y_back;

  assign accept    = start && !busy;
  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign y_back    = sat32(DIV_W'(qround(prod)) + DIV_W'($signed(beta_q)));

  tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_alpha (
    .clk(clk), .we(alpha_we), .waddr(alpha_wa), .wdata(alpha_wd),
    .raddr(ab_ra), .rdata(alpha_q)
  );
  tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_beta (
    .clk(clk), .we(beta_we), .waddr(beta_wa), .wdata(beta_wd),
    .raddr(ab_ra), .rdata(beta_q)
  );
  tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_sol (
    .clk(clk), .we(sol_we), .waddr(sol_wa), .wdata(sol_wd),
    .raddr(idx), .rdata(sol_q)
  );

  tss_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den), .res(dv)
  );

  always_comb begin
    state_next = state;
    alpha_we = 1'b0;  alpha_wa = AW'(row_count + 1'b1);  alpha_wd = dv.quot;
    beta_we  = 1'b0;  beta_wa  = AW'(row_count + 1'b1);  beta_wd  = dv.quot;
    sol_we   = 1'b0;  sol_wa   = idx;                    sol_wd   = y_back;
    ab_ra    = row_count;
    mul_x    = a_r;
    mul_y    = $signed(alpha_q);
    dv_start = 1'b0;
    dv_num   = DIV_W'(b_r);
    dv_den   = den_r;
    result_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_START: begin
              alpha_we = 1'b1;  alpha_wa = '0;  alpha_wd = left_kappa;
              beta_we  = 1'b1;  beta_wa  = '0;  beta_wd  = boundary_value;
            end
            KIND_ROW: begin
              if (row_count < AW'(MAX_NODES - 2)) state_next = ST_ROW_MA;
            end
            KIND_CLOSE: state_next = ST_CL_MB;
            default: ;
          endcase
        end
      end
      ST_ROW_MA: state_next = ST_ROW_MB;
      ST_ROW_MB: begin
        mul_y = $signed(beta_q);
        state_next = ST_ROW_DA;
      end
      ST_ROW_DA: begin
        dv_start = 1'b1;
        state_next = ST_ROW_WA;
      end
      ST_ROW_WA: begin
        dv_num = num_r;
        if (dv.done) begin
          alpha_we = 1'b1;
          dv_start = 1'b1;
          state_next = ST_ROW_WB;
        end
      end
      ST_ROW_WB: begin
        if (dv.done) begin
          beta_we = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CL_MB: begin
        mul_x = $signed(right_kappa);
        mul_y = $signed(beta_q);
        state_next = ST_CL_MA;
      end
      ST_CL_MA: begin
        mul_x = $signed(right_kappa);
        state_next = ST_CL_DV;
      end
      ST_CL_DV: begin
        dv_start = 1'b1;
        dv_num = num_r;
        dv_den = ONE_Q16 - DIV_W'(qround(prod));
        state_next = ST_CL_WY;
      end
      ST_CL_WY: begin
        if (dv.done) begin
          sol_we = 1'b1;  sol_wa = n_r;  sol_wd = dv.quot;
          state_next = ST_BK_RD;
        end
      end
      ST_BK_RD: begin
        ab_ra = idx;
        state_next = ST_BK_MUL;
      end
      ST_BK_MUL: begin
        ab_ra = idx;
        mul_x = $signed(alpha_q);
        mul_y = $signed(y_r);
        state_next = ST_BK_ADD;
      end
      ST_BK_ADD: begin
        ab_ra = idx;
        sol_we = 1'b1;
        state_next = (idx == '0) ? ST_EM_RD : ST_BK_RD;
      end
      ST_EM_RD: state_next = ST_EM_OUT;
      ST_EM_OUT: begin
        result_valid = 1'b1;
        state_next = (idx == n_r) ? ST_IDLE : ST_EM_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign solution   = sol_q;
  assign node_index = NODE_W'(idx);
  assign last       = idx == n_r;
  assign div_error  = error_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      left_kappa  <= '0;
      right_kappa <= '0;
      row_count   <= '0;
      error_seen  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LEFT_KAPPA) left_kappa <= cfg_data;
        else if (cfg_index == CFG_RIGHT_KAPPA) right_kappa <= cfg_data;
      end
      if (accept && kind == KIND_START) begin
        row_count  <= '0;
        error_seen <= 1'b0;
      end
      if (dv.done && dv.zero) error_seen <= 1'b1;
      if (state == ST_ROW_WB && dv.done) row_count <= row_count + 1'b1;
      if (state == ST_EM_OUT && last) begin
        row_count  <= '0;
        error_seen <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
    if (accept) begin
      a_r  <= $signed(sub_coef);
      b_r  <= $signed(super_coef);
      c_r  <= $signed(diag_coef);
      f_r  <= $signed(rhs_value);
      bv_r <= $signed(boundary_value);
      n_r  <= AW'(row_count + 1'b1);
    end
    case (state)
      ST_ROW_MB: den_r <= DIV_W'(c_r) - DIV_W'(qround(prod));
      ST_ROW_DA: num_r <= DIV_W'(f_r) + DIV_W'(qround(prod));
      ST_CL_MA:  num_r <= DIV_W'(bv_r) + DIV_W'(qround(prod));
      ST_CL_WY: begin
        y_r <= dv.quot;
        idx <= AW'(n_r - 1'b1);
      end
      ST_BK_ADD: begin
        y_r <= y_back;
        if (idx != '0) idx <= idx - 1'b1;
      end
      ST_EM_OUT: idx <= idx + 1'b1;
      default: ;
    endcase
  end

  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside a solve");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !busy && row_count == '0 && !error_seen)
    else $error("solve state not cleared after last word");
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("back-to-back result words");
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    dv.done |-> busy) else $error("divider finished while idle");

endmodule

// ===== rtl/tss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tss_div.sv =====
// Iterative restoring divider: Q16.16 quotient, rounded and saturated, one bit a cycle.
// Depends on tss_pkg.
module tss_div import tss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] num,
  input  logic signed [DIV_W-1:0] den,
  output tss_div_res_t            res
);

  tss_div_state_t    state;
  logic [MAG_W-1:0]  rem;
  logic [MAG_W-1:0]  dmag;
  logic [31:0]       nlow;
  logic [31:0]       quo;
  logic              neg;
  logic              big;
  logic [4:0]        cnt;

  logic [MAG_W-1:0]  nmag_in;
  logic [MAG_W-1:0]  dmag_in;
  logic [64:0]       nfull;
  logic [MAG_W:0]    trial;
  logic              fits;
  logic [32:0]       qm;

  always_comb begin
    nmag_in = num[DIV_W-1] ? MAG_W'(-num) : MAG_W'(num);
    dmag_in = den[DIV_W-1] ? MAG_W'(-den) : MAG_W'(den);
    nfull   = ({17'd0, nmag_in} << 16) + 65'(dmag_in >> 1);
    trial   = {rem, nlow[31]};
    fits    = trial >= {1'b0, dmag};
    if (big || quo > 32'h8000_0000) qm = 33'h0_8000_0000;
    else qm = {1'b0, quo};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DV_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) begin
            if (den == '0) begin
              res.done <= 1'b1;
              res.zero <= 1'b1;
              if (num > 0) res.quot <= POS_MAX;
              else if (num < 0) res.quot <= NEG_MIN;
              else res.quot <= '0;
            end else begin
              neg   <= num[DIV_W-1] != den[DIV_W-1];
              dmag  <= dmag_in;
              big   <= nfull[64:32] >= 33'(dmag_in);
              rem   <= MAG_W'(nfull[64:32]);
              nlow  <= nfull[31:0];
              quo   <= '0;
              cnt   <= '0;
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          // remainder stays below the divisor unless the quotient overflows
          if (!big) begin
            rem <= fits ? MAG_W'(trial - {1'b0, dmag}) : MAG_W'(trial);
            quo <= {quo[30:0], fits};
          end
          nlow <= {nlow[30:0], 1'b0};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) state <= DV_FIN;
        end
        DV_FIN: begin
          res.done <= 1'b1;
          res.zero <= 1'b0;
          if (neg) res.quot <= DATA_W'(-qm);
          else if (qm[32] || qm[31]) res.quot <= POS_MAX;
          else res.quot <= qm[31:0];
          state <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule
